[sv/cqvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqvs_pkg
// Types, codes and helpers shared by the clipped quad vertex setup unit.
// ----------------------------------------------------------------------------
package cqvs_pkg;

	localparam int CLIP_DEPTH_DEF = 16;

	localparam logic [1:0] FUNC_QUAD  = 2'd0;
	localparam logic [1:0] FUNC_PUSH  = 2'd1;
	localparam logic [1:0] FUNC_POP   = 2'd2;
	localparam logic [1:0] FUNC_BEGIN = 2'd3;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam int CFG_DATA_W = 12;

	localparam int NUM_W = 33;
	localparam int DEN_W = 16;
	localparam int QUO_W = 32;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [15:0] rect_left;
		logic signed [15:0] rect_top;
		logic signed [15:0] rect_width;
		logic signed [15:0] rect_height;
		logic signed [15:0] uv_left;
		logic signed [15:0] uv_top;
		logic signed [15:0] uv_width;
		logic signed [15:0] uv_height;
		logic [31:0]        fill_color;
		logic [15:0]        corner_radius;
		logic               quad_kind;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] tex_u;
		logic signed [15:0] tex_v;
		logic [31:0]        vertex_color;
		logic signed [15:0] local_x;
		logic signed [15:0] local_y;
		logic [14:0]        half_w;
		logic [14:0]        half_h;
		logic [15:0]        vertex_radius;
		logic               vertex_kind;
		logic               last_vertex;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        w;
		logic [15:0]        h;
	} clip_rect_t;

	typedef struct packed {
		logic       capture;
		logic       clip_exec;
		logic       prep;
		logic       div_start;
		logic       div_latch;
		logic       load_out;
		logic [2:0] job;
		logic [2:0] vtx;
	} cqvs_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       visible;
		logic       div_done;
		logic       out_free;
	} cqvs_stat_t;

	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		if (v > 36'sd32767)
			return 16'sh7FFF;
		else if (v < -36'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

	// corner order (right?, bottom?): (0,0) (1,0) (1,1) (0,0) (1,1) (0,1)
	function automatic logic corner_right(input logic [2:0] k);
		return (k == 3'd1) || (k == 3'd2) || (k == 3'd4);
	endfunction

	function automatic logic corner_bottom(input logic [2:0] k);
		return (k == 3'd2) || (k == 3'd4) || (k == 3'd5);
	endfunction

endpackage

[sv/clipped_quad_vertex_setup_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_quad_vertex_setup_unit
// Clipped overlay quad setup: clip stack and six-vertex generation.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_item) takes one command item: draw quad,
//   push clip, pop clip or begin frame. out channel (out_valid/out_ready/
//   out_item) gives six vertices per visible quad, last one flagged.
//   cfg_we/cfg_idx/cfg_wdata write screen width (0) and height (1); write
//   only while idle.
// Timing:
//   A quad runs eight divide jobs (four uv remaps, four normalizations)
//   through one 32-step restoring divider, each as prep, start, 32 steps
//   and latch, then loads its six vertices. A culled quad or a clip item
//   returns to idle after its clip step. The shared divider sets the rate.
// Reset:
//   clip stack empty, screen size 1x1, no item in flight.
// Stall:
//   vertices sit in the output register until taken; the sequencer holds.
//   The next item can be taken while the last vertex still waits.
// ----------------------------------------------------------------------------
module clipped_quad_vertex_setup_unit
	import cqvs_pkg::*;
#(
	parameter int CLIP_DEPTH = CLIP_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cqvs_cmd_t  cmd;
	cqvs_stat_t stat;

	cqvs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	cqvs_dp #(
		.CLIP_DEPTH(CLIP_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

endmodule

[sv/cqvs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqvs_div
// Radix-2 restoring divider, rounds to nearest with halves away from zero.
// ----------------------------------------------------------------------------
module cqvs_div
	import cqvs_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic signed [NUM_W:0]   quo
);

	logic             busy_q;
	logic             done_q;
	logic [4:0]       cnt_q;
	logic [QUO_W-1:0] mq_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [NUM_W-1:0] mag;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign trial = {rem_q[DEN_W-1:0], mq_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mq_q  <= QUO_W'(mag + NUM_W'(den >> 1));
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NUM_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			mq_q  <= {mq_q[QUO_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed({2'b00, mq_q}) : $signed({2'b00, mq_q});

endmodule

[sv/cqvs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqvs_dp
// Datapath: item and config registers, clip stack, intersect, remap and
// normalize jobs through a shared divider, vertex output register.
// ----------------------------------------------------------------------------
module cqvs_dp
	import cqvs_pkg::*;
#(
	parameter int CLIP_DEPTH = CLIP_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cqvs_cmd_t             cmd,
	output cqvs_stat_t            stat,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CW = $clog2(CLIP_DEPTH + 1);
	localparam int AW = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;

	in_item_t                  item_q;
	logic [11:0]               scr_w_q, scr_h_q;
	logic [CW-1:0]             count_q;
	clip_rect_t                mem [CLIP_DEPTH];
	clip_rect_t                rd_q;
	logic [AW-1:0]             rd_addr;
	logic [11:0]               scr_w_eff, scr_h_eff;

	logic signed [15:0]        cur_x, cur_y;
	logic signed [17:0]        cur_w, cur_h;
	logic signed [15:0]        rx, ry, rw, rh;
	logic signed [18:0]        r_right, r_bottom, c_right, c_bottom;
	logic signed [15:0]        ix, iy;
	logic signed [18:0]        iright, ibottom, iw, ih;
	logic [15:0]               cw_clamp, ch_clamp;
	logic                      visible;

	logic signed [15:0]        vis_x_s1, vis_y_s1;
	logic signed [18:0]        vis_x1_s1, vis_y1_s1;

	logic signed [18:0]        job_c, job_start, job_diff;
	logic signed [15:0]        job_tsize, job_to;
	logic [15:0]               job_rsize;
	logic signed [NUM_W-1:0]   num_s1;
	logic [DEN_W-1:0]          den_s1;
	logic signed [NUM_W-1:0]   prep_num;
	logic [DEN_W-1:0]          prep_den;
	logic                      div_done;
	logic signed [NUM_W:0]     quo;
	logic signed [35:0]        fin;
	logic signed [15:0]        res_q [8];

	logic                      xs, ys;
	logic signed [18:0]        xc, yc;
	logic signed [20:0]        tx, ty;
	logic [16:0]               hw_sum, hh_sum;
	logic                      out_valid_q;
	out_item_t                 out_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= 12'd1;
			scr_h_q <= 12'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SCREEN_WIDTH:  scr_w_q <= cfg_wdata;
				CFG_SCREEN_HEIGHT: scr_h_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign scr_w_eff = (scr_w_q == 12'd0) ? 12'd1 : scr_w_q;
	assign scr_h_eff = (scr_h_q == 12'd0) ? 12'd1 : scr_h_q;

	always_ff @(posedge clk) begin
		if (cmd.capture)
			item_q <= in_item;
	end

	// clip stack
	assign rd_addr = AW'(count_q - CW'(1));

	always_ff @(posedge clk) begin
		if (count_q != '0)
			rd_q <= mem[rd_addr];
		if (cmd.clip_exec && item_q.func == FUNC_PUSH && count_q < CW'(CLIP_DEPTH))
			mem[count_q[AW-1:0]] <= '{x: ix, y: iy, w: cw_clamp, h: ch_clamp};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clip_exec) begin
			unique case (item_q.func)
				FUNC_PUSH:  if (count_q < CW'(CLIP_DEPTH)) count_q <= count_q + CW'(1);
				FUNC_POP:   if (count_q != '0) count_q <= count_q - CW'(1);
				FUNC_BEGIN: count_q <= '0;
				default: ;
			endcase
		end
	end

	// intersect with current clip
	always_comb begin
		if (count_q == '0) begin
			cur_x = '0;
			cur_y = '0;
			cur_w = $signed({2'b00, scr_w_eff, 4'b0000});
			cur_h = $signed({2'b00, scr_h_eff, 4'b0000});
		end else begin
			cur_x = rd_q.x;
			cur_y = rd_q.y;
			cur_w = $signed({2'b00, rd_q.h[15:0]}) & 18'sd0 | $signed({2'b00, rd_q.w});
			cur_h = $signed({2'b00, rd_q.h});
		end
	end

	assign rx = item_q.rect_left;
	assign ry = item_q.rect_top;
	assign rw = item_q.rect_width;
	assign rh = item_q.rect_height;

	assign r_right  = 19'(rx) + 19'(rw);
	assign r_bottom = 19'(ry) + 19'(rh);
	assign c_right  = 19'(cur_x) + 19'(cur_w);
	assign c_bottom = 19'(cur_y) + 19'(cur_h);

	assign ix      = (rx > cur_x) ? rx : cur_x;
	assign iy      = (ry > cur_y) ? ry : cur_y;
	assign iright  = (r_right < c_right) ? r_right : c_right;
	assign ibottom = (r_bottom < c_bottom) ? r_bottom : c_bottom;
	assign iw      = iright - 19'(ix);
	assign ih      = ibottom - 19'(iy);

	assign cw_clamp = iw[18] ? 16'd0 : ((iw > 19'sd32767) ? 16'd32767 : iw[15:0]);
	assign ch_clamp = ih[18] ? 16'd0 : ((ih > 19'sd32767) ? 16'd32767 : ih[15:0]);

	assign visible = (rw > 16'sd0) && (rh > 16'sd0) && (iw > 19'sd0) && (ih > 19'sd0);

	always_ff @(posedge clk) begin
		if (cmd.clip_exec) begin
			vis_x_s1  <= ix;
			vis_y_s1  <= iy;
			vis_x1_s1 <= iright;
			vis_y1_s1 <= ibottom;
		end
	end

	// divide jobs: 0..3 remap u0 u1 v0 v1, 4..7 pos x0 x1 y0 y1
	always_comb begin
		if (cmd.job[1])
			job_c = cmd.job[0] ? vis_y1_s1 : 19'(vis_y_s1);
		else
			job_c = cmd.job[0] ? vis_x1_s1 : 19'(vis_x_s1);
		job_start = cmd.job[1] ? 19'(ry) : 19'(rx);
		job_rsize = cmd.job[1] ? rh : rw;
		job_tsize = cmd.job[1] ? item_q.uv_height : item_q.uv_width;
		job_diff  = job_c - job_start;
		if (cmd.job[2]) begin
			prep_num = NUM_W'(job_c) <<< 11;
			prep_den = DEN_W'(cmd.job[1] ? scr_h_eff : scr_w_eff);
		end else begin
			prep_num = NUM_W'($signed({1'b0, job_diff[15:0]}) * job_tsize);
			prep_den = job_rsize;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			num_s1 <= prep_num;
			den_s1 <= prep_den;
		end
	end

	cqvs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (num_s1),
		.den   (den_s1),
		.done  (div_done),
		.quo   (quo)
	);

	assign job_to = cmd.job[1] ? item_q.uv_top : item_q.uv_left;

	always_comb begin
		unique case (cmd.job[2:1])
			2'b00, 2'b01: fin = 36'(job_to) + 36'(quo);
			2'b10:        fin = 36'(quo) - 36'sd16384;
			default:      fin = 36'sd16384 - 36'(quo);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.div_latch)
			res_q[cmd.job] <= sat16(fin);
	end

	// vertex assembly
	assign xs = corner_right(cmd.vtx);
	assign ys = corner_bottom(cmd.vtx);
	assign xc = xs ? vis_x1_s1 : 19'(vis_x_s1);
	assign yc = ys ? vis_y1_s1 : 19'(vis_y_s1);
	assign tx = ((21'(xc) - 21'(rx)) <<< 1) - 21'(rw) + 21'sd1;
	assign ty = ((21'(yc) - 21'(ry)) <<< 1) - 21'(rh) + 21'sd1;
	assign hw_sum = 17'(rw) + 17'd1;
	assign hh_sum = 17'(rh) + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.pos_x         <= res_q[{2'b10, xs}];
			out_q.pos_y         <= res_q[{2'b11, ys}];
			out_q.tex_u         <= res_q[{2'b00, xs}];
			out_q.tex_v         <= res_q[{2'b01, ys}];
			out_q.vertex_color  <= item_q.fill_color;
			out_q.local_x       <= sat16(36'(tx >>> 1));
			out_q.local_y       <= sat16(36'(ty >>> 1));
			out_q.half_w        <= hw_sum[15:1];
			out_q.half_h        <= hh_sum[15:1];
			out_q.vertex_radius <= item_q.corner_radius;
			out_q.vertex_kind   <= item_q.quad_kind;
			out_q.last_vertex   <= (cmd.vtx == 3'd5);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign stat.func     = item_q.func;
	assign stat.visible  = visible;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

[sv/cqvs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqvs_ctrl
// Sequencer: accept, clip step, eight divide jobs, six vertex loads.
// ----------------------------------------------------------------------------
module cqvs_ctrl
	import cqvs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  cqvs_stat_t stat,
	output cqvs_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLIP,
		S_PREP,
		S_START,
		S_WAIT,
		S_EMIT
	} state_t;

	state_t     state_q;
	logic [2:0] job_q;
	logic [2:0] vtx_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.job       = job_q;
		cmd.vtx       = vtx_q;
		cmd.capture   = in_ready && in_valid;
		cmd.clip_exec = (state_q == S_CLIP);
		cmd.prep      = (state_q == S_PREP);
		cmd.div_start = (state_q == S_START);
		cmd.div_latch = (state_q == S_WAIT) && stat.div_done;
		cmd.load_out  = (state_q == S_EMIT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= '0;
			vtx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_CLIP;
				end
				S_CLIP: begin
					job_q <= '0;
					if (stat.func == FUNC_QUAD && stat.visible)
						state_q <= S_PREP;
					else
						state_q <= S_IDLE;
				end
				S_PREP: state_q <= S_START;
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (stat.div_done) begin
						if (job_q == 3'd7) begin
							vtx_q   <= '0;
							state_q <= S_EMIT;
						end else begin
							job_q   <= job_q + 3'd1;
							state_q <= S_PREP;
						end
					end
				end
				S_EMIT: begin
					if (stat.out_free) begin
						if (vtx_q == 3'd5)
							state_q <= S_IDLE;
						else
							vtx_q <= vtx_q + 3'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for clipped_quad_vertex_setup_unit.
// A queue-fed driver sends draw and clip-stack command items through a random
// gap generator. A fixed-point vertex predictor keeps its own clip stack and
// screen size and queues six expected vertices per visible quad. A monitor
// with random back-pressure checks every vertex field by field. The run walks
// several screen sizes, extremes included, and holds the output off once for
// a long stretch.
// ----------------------------------------------------------------------------
module testbench;
	import cqvs_pkg::*;

	localparam int  MAX_CYCLES = 1000000;
	localparam int  STACK_DEPTH = CLIP_DEPTH_DEF;
	localparam int  DRAIN_CYCLES = 50;
	localparam int  HOLD_AT_ITEM = 150;
	localparam int  HOLD_CYCLES = 3000;

	typedef struct {
		longint x;
		longint y;
		longint w;
		longint h;
	} area_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_item = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = CFG_SCREEN_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	in_item_t  pending_items[$];
	out_item_t vertex_queue[$];
	area_t     clip_shadow[STACK_DEPTH];
	int        clip_depth = 0;
	int        screen_w = 1;
	int        screen_h = 1;
	int        err_cnt = 0;
	int        in_count = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;
	int        cycle_cnt = 0;

	clipped_quad_vertex_setup_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic void enqueue(in_item_t it);
		pending_items = {pending_items, it};
	endfunction

	function automatic longint div_near(longint n, longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic longint half_down(longint t);
		if (t >= 0)
			return t / 2;
		return -((-t + 1) / 2);
	endfunction

	function automatic logic [15:0] clamp16(longint v);
		if (v > 32767)
			return 16'h7FFF;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	function automatic area_t active_clip();
		area_t c;
		if (clip_depth == 0) begin
			c.x = 0;
			c.y = 0;
			c.w = longint'(screen_w == 0 ? 1 : screen_w) * 16;
			c.h = longint'(screen_h == 0 ? 1 : screen_h) * 16;
			return c;
		end
		return clip_shadow[clip_depth-1];
	endfunction

	function automatic area_t overlap(area_t a, area_t b);
		area_t r;
		longint ar, br, ab, bb;
		ar = a.x + a.w;
		br = b.x + b.w;
		ab = a.y + a.h;
		bb = b.y + b.h;
		r.x = a.x > b.x ? a.x : b.x;
		r.y = a.y > b.y ? a.y : b.y;
		r.w = (ar < br ? ar : br) - r.x;
		r.h = (ab < bb ? ab : bb) - r.y;
		return r;
	endfunction

	function automatic longint tex_remap(longint v, longint from, longint size, longint to,
			longint tsize);
		return longint'($signed(clamp16(to + div_near((v - from) * tsize, size))));
	endfunction

	// updates the clip stack shadow and queues the vertices of a visible quad
	function automatic void predict_vertices(in_item_t it);
		area_t     r, vis, c;
		longint    cx[2], cy[2], cu[2], cv[2];
		longint    sw, sh, x, y;
		out_item_t v;
		bit        rt, bt;
		r.x = it.rect_left;
		r.y = it.rect_top;
		r.w = it.rect_width;
		r.h = it.rect_height;
		sw = screen_w == 0 ? 1 : screen_w;
		sh = screen_h == 0 ? 1 : screen_h;
		case (it.func)
			FUNC_PUSH: begin
				if (clip_depth < STACK_DEPTH) begin
					c = overlap(active_clip(), r);
					c.w = c.w < 0 ? 0 : (c.w > 32767 ? 32767 : c.w);
					c.h = c.h < 0 ? 0 : (c.h > 32767 ? 32767 : c.h);
					clip_shadow[clip_depth] = c;
					clip_depth++;
				end
			end
			FUNC_POP: begin
				if (clip_depth > 0)
					clip_depth--;
			end
			FUNC_BEGIN: clip_depth = 0;
			default: begin
				if (r.w <= 0 || r.h <= 0)
					return;
				vis = overlap(r, active_clip());
				if (vis.w <= 0 || vis.h <= 0)
					return;
				cx[0] = vis.x;
				cx[1] = vis.x + vis.w;
				cy[0] = vis.y;
				cy[1] = vis.y + vis.h;
				for (int i = 0; i < 2; i++) begin
					cu[i] = tex_remap(cx[i], r.x, r.w, it.uv_left, it.uv_width);
					cv[i] = tex_remap(cy[i], r.y, r.h, it.uv_top, it.uv_height);
				end
				for (int k = 0; k < 6; k++) begin
					rt = (k == 1) || (k == 2) || (k == 4);
					bt = (k == 2) || (k == 4) || (k == 5);
					x = cx[rt];
					y = cy[bt];
					v.pos_x = clamp16(div_near(x * 2048, sw) - 16384);
					v.pos_y = clamp16(16384 - div_near(y * 2048, sh));
					v.tex_u = cu[rt][15:0];
					v.tex_v = cv[bt][15:0];
					v.vertex_color = it.fill_color;
					v.local_x = clamp16(half_down(2 * (x - r.x) - r.w + 1));
					v.local_y = clamp16(half_down(2 * (y - r.y) - r.h + 1));
					v.half_w = 15'((r.w + 1) / 2);
					v.half_h = 15'((r.h + 1) / 2);
					v.vertex_radius = it.corner_radius;
					v.vertex_kind = it.quad_kind;
					v.last_vertex = (k == 5);
					vertex_queue = {vertex_queue, v};
				end
			end
		endcase
	endfunction

	function automatic in_item_t mk_item(logic [1:0] f, int l, int t, int w, int h, int ul,
			int ut, int uw, int uh, logic [31:0] col, logic [15:0] rad, logic kind);
		in_item_t it;
		it.func = f;
		it.rect_left = 16'(l);
		it.rect_top = 16'(t);
		it.rect_width = 16'(w);
		it.rect_height = 16'(h);
		it.uv_left = 16'(ul);
		it.uv_top = 16'(ut);
		it.uv_width = 16'(uw);
		it.uv_height = 16'(uh);
		it.fill_color = col;
		it.corner_radius = rad;
		it.quad_kind = kind;
		return it;
	endfunction

	function automatic in_item_t rand_item(logic [1:0] f);
		in_item_t it;
		int spanx, spany;
		spanx = (screen_w == 0 ? 1 : screen_w) * 16;
		spany = (screen_h == 0 ? 1 : screen_h) * 16;
		if (spanx > 30000)
			spanx = 30000;
		if (spany > 30000)
			spany = 30000;
		it = mk_item(f, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, 16'($urandom), 1'($urandom));
		if ($urandom_range(0, 4) != 0) begin
			it.rect_left = 16'(int'($urandom_range(0, spanx + spanx / 4)) - spanx / 8);
			it.rect_top = 16'(int'($urandom_range(0, spany + spany / 4)) - spany / 8);
			it.rect_width = 16'($urandom_range(1, spanx / 2 + 16));
			it.rect_height = 16'($urandom_range(1, spany / 2 + 16));
		end
		return it;
	endfunction

	function automatic logic [1:0] rand_func();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return FUNC_QUAD;
		if (p < 78)
			return FUNC_PUSH;
		if (p < 94)
			return FUNC_POP;
		return FUNC_BEGIN;
	endfunction

	function automatic int draw_gap();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			nv = in_valid;
			if (in_valid && in_ready) begin
				predict_vertices(in_item);
				in_count <= in_count + 1;
				nv = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_items.size() > 0) begin
					in_item <= pending_items.pop_front();
					nv = 1'b1;
					gap_left <= draw_gap();
				end
			end
			in_valid <= nv;
		end
	end

	// long output hold-off so the block fills up and stalls its input
	always @(posedge clk) begin
		if (!hold_done && in_count >= HOLD_AT_ITEM) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	function automatic void check_field(string name, longint e, longint a);
		if (e != a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			err_cnt++;
		end
	endfunction

	// monitor
	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		int ns;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			ns = stall_left;
			if (out_valid && out_ready) begin
				if (vertex_queue.size() == 0) begin
					$error("vertex with no expectation: %h", out_item);
					err_cnt++;
				end else begin
					e = vertex_queue.pop_front();
					check_field("pos_x", e.pos_x, out_item.pos_x);
					check_field("pos_y", e.pos_y, out_item.pos_y);
					check_field("tex_u", e.tex_u, out_item.tex_u);
					check_field("tex_v", e.tex_v, out_item.tex_v);
					check_field("vertex_color", e.vertex_color, out_item.vertex_color);
					check_field("local_x", e.local_x, out_item.local_x);
					check_field("local_y", e.local_y, out_item.local_y);
					check_field("half_w", e.half_w, out_item.half_w);
					check_field("half_h", e.half_h, out_item.half_h);
					check_field("vertex_radius", e.vertex_radius, out_item.vertex_radius);
					check_field("vertex_kind", e.vertex_kind, out_item.vertex_kind);
					check_field("last_vertex", e.last_vertex, out_item.last_vertex);
				end
				ns = draw_gap();
			end else if (ns > 0) begin
				ns--;
			end
			stall_left <= ns;
			out_ready <= (ns == 0) && (hold_left == 0);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= MAX_CYCLES) begin
			$display("** clipped_quad_vertex_setup_unit: FAILED **");
			$finish;
		end
	end

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || in_valid || vertex_queue.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SCREEN_WIDTH)
			screen_w = val;
		else
			screen_h = val;
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 39) == 0) begin
				// overfill the clip stack, draw under it, then start a new frame
				for (int j = 0; j < STACK_DEPTH + 2; j++)
					enqueue(rand_item(FUNC_PUSH));
				for (int j = 0; j < 3; j++)
					enqueue(rand_item(FUNC_QUAD));
				enqueue(rand_item(FUNC_BEGIN));
			end else begin
				enqueue(rand_item(rand_func()));
			end
		end
	endtask

	int sizes_w[6] = '{4095, 1, 0, 640, 17, 4095};
	int sizes_h[6] = '{4095, 4095, 0, 480, 1, 1};

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		queue_random(8);
		wait_idle();
		write_reg(CFG_SCREEN_WIDTH, 320);
		write_reg(CFG_SCREEN_HEIGHT, 240);
		enqueue(mk_item(FUNC_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		enqueue(mk_item(FUNC_QUAD, 16, 16, 160, 320, 0, 0, 16384, 16384,
			32'hFF00FF80, 16'd64, 1'b0));
		enqueue(mk_item(FUNC_QUAD, 16, 16, 0, 320, 0, 0, 16384, 16384,
			32'h1, 16'd0, 1'b0));
		enqueue(mk_item(FUNC_QUAD, 16, 16, 320, -16, 0, 0, 16384, 16384,
			32'h1, 16'd0, 1'b1));
		enqueue(mk_item(FUNC_QUAD, -32768, -32768, 32767, 32767, -32768,
			-32768, 32767, 32767, 32'hFFFFFFFF, 16'hFFFF, 1'b1));
		enqueue(mk_item(FUNC_QUAD, 32767, 100, 32767, 32767, 32767, 32767,
			-32768, -32768, 32'h0, 16'h0, 1'b0));
		enqueue(mk_item(FUNC_QUAD, -4000, -4000, 8000, 8000, -32768, 32767,
			-32768, 32767, 32'h12345678, 16'h8000, 1'b1));
		enqueue(mk_item(FUNC_QUAD, 5, 7, 3, 5, 100, -100, 333, -777,
			32'hA5A5A5A5, 16'h5A5A, 1'b0));
		enqueue(mk_item(FUNC_PUSH, 800, 800, 1600, 1600, 0, 0, 0, 0, 0, 0, 0));
		enqueue(mk_item(FUNC_QUAD, 0, 0, 5120, 3840, 0, 0, 16384, 16384,
			32'h00FF00FF, 16'd32, 1'b1));
		enqueue(mk_item(FUNC_PUSH, 3000, 3000, 100, 100, 0, 0, 0, 0, 0, 0, 0));
		enqueue(mk_item(FUNC_QUAD, 0, 0, 5120, 3840, 0, 0, 16384, 16384,
			32'h1, 16'd1, 1'b0));
		enqueue(mk_item(FUNC_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		enqueue(mk_item(FUNC_QUAD, 1000, 1000, 32767, 32767, 0, 0, 32767,
			32767, 32'h2, 16'd2, 1'b1));
		enqueue(mk_item(FUNC_PUSH, -32768, -32768, -1, 32767, 0, 0, 0, 0, 0,
			0, 0));
		enqueue(mk_item(FUNC_QUAD, 0, 0, 100, 100, 0, 0, 100, 100, 32'h3,
			16'd3, 1'b0));
		enqueue(mk_item(FUNC_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		enqueue(mk_item(FUNC_QUAD, 5119, 3839, 1, 1, 0, 0, 1, 1, 32'h4,
			16'd4, 1'b1));
		queue_random(90);
		wait_idle();
		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_SCREEN_WIDTH, sizes_w[p]);
			write_reg(CFG_SCREEN_HEIGHT, sizes_h[p]);
			queue_random(p == 3 ? 110 : 35);
			wait_idle();
		end
		if (err_cnt == 0 && vertex_queue.size() == 0)
			$display("** clipped_quad_vertex_setup_unit: PASSED **");
		else
			$display("** clipped_quad_vertex_setup_unit: FAILED **");
		$finish;
	end

endmodule
